FILE: sv/assert_macros.svh
// Assertion macros shared by the depth-first search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ADFS_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ADFS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/adfs_pkg.sv
// Shared widths, request kind codes and the adjacency memory control group.
package adfs_pkg;

    localparam int KIND_W   = 2;
    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;

    // Request kind codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 2'd0,
        KIND_SEARCH   = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_RESERVED = 2'd3
    } kind_t;

    // Control group from the sequencer to the adjacency memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } adfs_mat_ctl_t;

endpackage

FILE: sv/adjacency_matrix_depth_first_search.sv
// Directed graph as an adjacency bit matrix with a depth-first walk sequencer.
// Add edge reads the source row and writes it back with the new bit; clear
// drops all rows; neither gives a result. A search descends to each
// discovered vertex by a priority pick plus push and leaves each finished
// vertex by an empty scan plus stack pop, all through the single row read
// port of the adjacency memory feeding one shared lowest-bit encoder. An
// output stall holds any descent or result. The block takes no new request
// while a request is in progress; in_stall is high for that time. Each
// vertex is reported once in visit order and the final one carries last.
module adjacency_matrix_depth_first_search #(
    parameter int VERTICES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [adfs_pkg::COUNT_W-1:0]  vertex_count,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [adfs_pkg::KIND_W-1:0]   kind,
    input  logic [adfs_pkg::VERTEX_W-1:0] source_vertex,
    input  logic [adfs_pkg::VERTEX_W-1:0] dest_vertex,
    input  logic [adfs_pkg::VERTEX_W-1:0] start_vertex,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [adfs_pkg::VERTEX_W-1:0] visited_vertex,
    output logic                          last,
    output logic                          bad_start
);
    import adfs_pkg::*;
`include "assert_macros.svh"

    localparam int VW = $clog2(VERTICES);
    localparam int DW = $clog2(VERTICES + 1);
    localparam logic [COUNT_W-1:0] VMAX = COUNT_W'(VERTICES);
    localparam logic [VERTICES-1:0] ONE_BIT = VERTICES'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_BAD,
        ST_SCAN,
        ST_POP,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    vcount_reg;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [VW-1:0]         top_reg, top_next;
    logic [VW-1:0]         pending_reg, pending_next;
    logic [VW-1:0]         src_reg, src_next;
    logic [VW-1:0]         dst_reg, dst_next;
    logic [VERTEX_W-1:0]   start_reg, start_next;
    logic [VERTICES-1:0]   visited_reg, visited_next;
    logic                  out_valid_reg;
    logic [VERTEX_W-1:0]   visited_vertex_reg;
    logic                  last_reg;
    logic                  bad_start_reg;

    logic [COUNT_W-1:0]    n_eff;
    logic [VERTICES-1:0]   mask;
    logic [VERTICES-1:0]   row;
    logic [VERTICES-1:0]   cand;
    logic                  found;
    logic [VW-1:0]         next_idx;
    logic                  out_free;
    logic [DW-1:0]         depth_m1;
    logic [DW-1:0]         depth_m2;
    logic                  edge_ok;
    logic                  start_ok;

    adfs_mat_ctl_t         mat_ctl;
    logic [VW-1:0]         mat_raddr;
    logic [VERTICES-1:0]   mat_wdata;
    logic                  stk_wr;
    logic                  stk_rd;
    logic [VW-1:0]         stk_rdata;

    logic                  out_load;
    logic [VERTEX_W-1:0]   out_vtx;
    logic                  out_last;
    logic                  out_bad;

    // Effective vertex count and the mask of vertices in use
    assign n_eff = (vcount_reg > VMAX) ? VMAX : vcount_reg;

    always_comb
    begin
        for (int i = 0; i < VERTICES; i++)
        begin
            mask[i] = (COUNT_W'(i) < n_eff);
        end
    end

    assign edge_ok  = (COUNT_W'(source_vertex) < n_eff) && (COUNT_W'(dest_vertex) < n_eff);
    assign start_ok = (COUNT_W'(start_vertex) < n_eff);

    // Candidates: unvisited neighbors of the top vertex
    assign cand = row & ~visited_reg & mask;

    adfs_prio #(
        .VERTICES (VERTICES),
        .VW       (VW)
    ) u_prio (
        .cand  (cand),
        .found (found),
        .idx   (next_idx)
    );

    adfs_matrix #(
        .VERTICES (VERTICES),
        .VW       (VW)
    ) u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mat_ctl),
        .raddr (mat_raddr),
        .waddr (src_reg),
        .wdata (mat_wdata),
        .row   (row)
    );

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);

    adfs_stack #(
        .VW (VW)
    ) u_stack (
        .clk   (clk),
        .wr_en (stk_wr),
        .waddr (depth_m1[VW-1:0]),
        .wdata (top_reg),
        .rd_en (stk_rd),
        .raddr (depth_m2[VW-1:0]),
        .rdata (stk_rdata)
    );

    // Merge the new edge into the row read on the previous cycle
    assign mat_wdata = row | (ONE_BIT << dst_reg);

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer next-state logic
    always_comb
    begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        top_next     = top_reg;
        pending_next = pending_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        start_next   = start_reg;
        visited_next = visited_reg;
        mat_ctl      = '0;
        mat_raddr    = next_idx;
        stk_wr       = 1'b0;
        stk_rd       = 1'b0;
        out_load     = 1'b0;
        out_vtx      = VERTEX_W'(pending_reg);
        out_last     = 1'b0;
        out_bad      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    src_next   = source_vertex[VW-1:0];
                    dst_next   = dest_vertex[VW-1:0];
                    start_next = start_vertex;
                    unique case (kind_t'(kind))
                        KIND_ADD:
                        begin
                            if (edge_ok)
                            begin
                                mat_ctl.rd_en = 1'b1;
                                mat_raddr     = source_vertex[VW-1:0];
                                state_next    = ST_ADD;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            if (start_ok)
                            begin
                                visited_next  = ONE_BIT << start_vertex[VW-1:0];
                                top_next      = start_vertex[VW-1:0];
                                pending_next  = start_vertex[VW-1:0];
                                depth_next    = DW'(1);
                                mat_ctl.rd_en = 1'b1;
                                mat_raddr     = start_vertex[VW-1:0];
                                state_next    = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_BAD;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            mat_ctl.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                mat_ctl.wr_en = 1'b1;
                state_next    = ST_IDLE;
            end

            ST_BAD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_vtx    = start_reg;
                    out_last   = 1'b1;
                    out_bad    = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (found)
                begin
                    // Descend: release the held vertex, push the top, fetch the new row
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        visited_next  = visited_reg | (ONE_BIT << next_idx);
                        stk_wr        = 1'b1;
                        top_next      = next_idx;
                        pending_next  = next_idx;
                        depth_next    = depth_reg + DW'(1);
                        mat_ctl.rd_en = 1'b1;
                        mat_raddr     = next_idx;
                    end
                end
                else if (depth_reg == DW'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // Back up one level
                    stk_rd     = 1'b1;
                    depth_next = depth_m1;
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                top_next      = stk_rdata;
                mat_ctl.rd_en = 1'b1;
                mat_raddr     = stk_rdata;
                state_next    = ST_SCAN;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, walk registers and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            vcount_reg         <= VMAX;
            depth_reg          <= '0;
            top_reg            <= '0;
            pending_reg        <= '0;
            src_reg            <= '0;
            dst_reg            <= '0;
            start_reg          <= '0;
            visited_reg        <= '0;
            out_valid_reg      <= 1'b0;
            visited_vertex_reg <= '0;
            last_reg           <= 1'b0;
            bad_start_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            top_reg     <= top_next;
            pending_reg <= pending_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            start_reg   <= start_next;
            visited_reg <= visited_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= vertex_count;
            end
            if (out_load)
            begin
                out_valid_reg      <= 1'b1;
                visited_vertex_reg <= out_vtx;
                last_reg           <= out_last;
                bad_start_reg      <= out_bad;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready      = 1'b1;
    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign visited_vertex = visited_vertex_reg;
    assign last           = last_reg;
    assign bad_start      = bad_start_reg;

    // Walk depth stays between one and the vertex count
    `ADFS_ASSERT_IMPLY(a_walk_depth, state_reg == ST_SCAN || state_reg == ST_POP, depth_reg != '0 && COUNT_W'(depth_reg) <= n_eff, "walk depth out of range")
    // The vertex held for output is always marked visited
    `ADFS_ASSERT_IMPLY(a_pending_seen, state_reg == ST_SCAN || state_reg == ST_DONE, visited_reg[pending_reg], "held vertex not marked visited")
    // A descent marks the new top vertex visited
    `ADFS_ASSERT_NEXT(a_push_marks, state_reg == ST_SCAN && found && out_free, visited_reg[top_reg] && top_reg == pending_reg, "descent did not mark new top")
    // A bad start result always closes its search
    `ADFS_ASSERT_IMPLY(a_bad_is_last, out_valid_reg && bad_start_reg, last_reg, "bad start result without last")

endmodule

FILE: sv/adfs_prio.sv
// Lowest-set-bit priority encoder used to pick the next neighbor.
module adfs_prio #(
    parameter int VERTICES = 64,
    parameter int VW       = 6
) (
    input  logic [VERTICES-1:0] cand,
    output logic                found,
    output logic [VW-1:0]       idx
);

    // Scan from the top so the lowest set bit wins
    always_comb
    begin
        idx = '0;
        for (int i = VERTICES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                idx = VW'(i);
            end
        end
    end

    assign found = |cand;

endmodule

FILE: sv/adfs_matrix.sv
// Adjacency row memory with per-row valid bits and a registered read port.
module adfs_matrix #(
    parameter int VERTICES = 64,
    parameter int VW       = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  adfs_pkg::adfs_mat_ctl_t ctl,
    input  logic [VW-1:0]           raddr,
    input  logic [VW-1:0]           waddr,
    input  logic [VERTICES-1:0]     wdata,
    output logic [VERTICES-1:0]     row
);
    import adfs_pkg::*;

    logic [VERTICES-1:0] mem [VERTICES];
    logic [VERTICES-1:0] row_valid_reg;
    logic [VERTICES-1:0] rdata_reg;
    logic                rvalid_reg;

    // Track which rows hold data; clear drops every row at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                row_valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                row_valid_reg[waddr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rvalid_reg <= row_valid_reg[raddr];
            end
        end
    end

    // Write and read the row array
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // A row never written since the last clear reads as empty
    assign row = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: sv/adfs_stack.sv
// Walk stack memory holding the vertices of the open levels below the top.
module adfs_stack #(
    parameter int VW = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [VW-1:0] waddr,
    input  logic [VW-1:0] wdata,
    input  logic          rd_en,
    input  logic [VW-1:0] raddr,
    output logic [VW-1:0] rdata
);

    localparam int DEPTH = 1 << VW;

    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] rdata_reg;

    // Push writes one entry, pop reads one entry into a register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: test/adjacency_matrix_depth_first_search_tb.sv
// Self-checking testbench for the adjacency matrix depth-first search block.
module adjacency_matrix_depth_first_search_tb;

    import adfs_pkg::*;

    typedef struct packed {
        kind_t               kind;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dst;
        logic [VERTEX_W-1:0] start;
    } graph_req_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                is_last;
        logic                is_bad;
    } visit_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  vertex_count = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [KIND_W-1:0]   kind = '0;
    logic [VERTEX_W-1:0] source_vertex = '0;
    logic [VERTEX_W-1:0] dest_vertex = '0;
    logic [VERTEX_W-1:0] start_vertex = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VERTEX_W-1:0] visited_vertex;
    logic                last;
    logic                bad_start;

    // Predictor state: edge matrix and the vertex count last written
    logic [63:0] graph_rows [64];
    int          count_setting = 64;

    graph_req_t request_q [$];
    visit_t     visit_order_q [$];
    graph_req_t next_req;
    visit_t     want_visit;
    int         send_gap = 0;
    int         stall_left = 0;
    int         mismatch_count = 0;
    logic       quiet = 1'b0;

    adjacency_matrix_depth_first_search u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .vertex_count   (vertex_count),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .source_vertex  (source_vertex),
        .dest_vertex    (dest_vertex),
        .start_vertex   (start_vertex),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .visited_vertex (visited_vertex),
        .last           (last),
        .bad_start      (bad_start)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int active_vertices();
        return (count_setting > 64) ? 64 : count_setting;
    endfunction

    // Update the edge matrix and queue the visit order a request produces
    task automatic apply_request(input logic [KIND_W-1:0] k, input logic [VERTEX_W-1:0] s,
                                 input logic [VERTEX_W-1:0] d, input logic [VERTEX_W-1:0] st);
        int          n;
        int          depth;
        int          nxt;
        logic [63:0] mask;
        logic [63:0] seen;
        logic [63:0] cand;
        logic [5:0]  path [64];
        visit_t      held;
        n = active_vertices();
        mask = (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
        case (k)
            KIND_ADD:
            begin
                if (int'(s) < n && int'(d) < n)
                    graph_rows[s][d] = 1'b1;
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < 64; i++)
                    graph_rows[i] = '0;
            end
            KIND_SEARCH:
            begin
                if (int'(st) >= n)
                begin
                    held = '{vertex: st, is_last: 1'b1, is_bad: 1'b1};
                    visit_order_q.push_back(held);
                end
                else
                begin
                    seen = 64'd1 << st;
                    path[0] = st;
                    depth = 1;
                    held = '{vertex: st, is_last: 1'b0, is_bad: 1'b0};
                    // Descend into the lowest unvisited neighbor, pop when none is left
                    while (depth > 0)
                    begin
                        cand = graph_rows[path[depth-1]] & ~seen & mask;
                        if (cand == '0)
                            depth--;
                        else
                        begin
                            nxt = 0;
                            for (int i = 63; i >= 0; i--)
                                if (cand[i])
                                    nxt = i;
                            seen[nxt] = 1'b1;
                            path[depth] = nxt[5:0];
                            depth++;
                            visit_order_q.push_back(held);
                            held = '{vertex: nxt[5:0], is_last: 1'b0, is_bad: 1'b0};
                        end
                    end
                    held.is_last = 1'b1;
                    visit_order_q.push_back(held);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Request driver: present queued requests, with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            kind          <= '0;
            source_vertex <= '0;
            dest_vertex   <= '0;
            start_vertex  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_request(kind, source_vertex, dest_vertex, start_vertex);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap = send_gap - 1;
                end
                else if (request_q.size() > 0)
                begin
                    next_req = request_q.pop_front();
                    in_valid      <= 1'b1;
                    kind          <= next_req.kind;
                    source_vertex <= next_req.src;
                    dest_vertex   <= next_req.dst;
                    start_vertex  <= next_req.start;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each visit against the oldest expectation, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (visit_order_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: unexpected visit vertex %0d last %0b bad_start %0b",
                                 visited_vertex, last, bad_start);
                end
                else
                begin
                    want_visit = visit_order_q.pop_front();
                    if (visited_vertex !== want_visit.vertex || last !== want_visit.is_last ||
                        bad_start !== want_visit.is_bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: vertex %0d/%0d last %0b/%0b bad_start %0b/%0b %s",
                                     want_visit.vertex, visited_vertex, want_visit.is_last, last,
                                     want_visit.is_bad, bad_start, "(expected/actual)");
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 4);
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic queue_request(input kind_t k, input int s, input int d, input int st);
        graph_req_t r;
        r.kind  = k;
        r.src   = s[5:0];
        r.dst   = d[5:0];
        r.start = st[5:0];
        request_q.push_back(r);
    endtask

    // Hold until every request is taken and answered, then let the block settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || visit_order_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_vertex_count(input int value);
        @(posedge clk);
        cfg_valid    <= 1'b1;
        vertex_count <= value[COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        count_setting = value;
        cfg_valid <= 1'b0;
    endtask

    // Rounds of edge chains with random content followed by searches, plus noise
    task automatic queue_random_phase(input int budget);
        int n;
        int made;
        int tail;
        int pick;
        int s;
        int d;
        n = active_vertices();
        made = 0;
        tail = 0;
        while (made < budget)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                queue_request(KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 63));
                made++;
            end
            repeat ($urandom_range(2, 14))
            begin
                pick = $urandom_range(0, 15);
                if (pick == 1)
                    queue_request(KIND_RESERVED, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 63));
                else
                begin
                    if (n == 0 || pick == 0)
                    begin
                        s = $urandom_range(0, 63);
                        d = $urandom_range(0, 63);
                    end
                    else
                    begin
                        s = ($urandom_range(0, 1) == 1) ? tail : $urandom_range(0, n - 1);
                        d = $urandom_range(0, n - 1);
                        tail = d;
                    end
                    queue_request(KIND_ADD, s, d, $urandom_range(0, 63));
                    made++;
                end
            end
            repeat ($urandom_range(1, 3))
            begin
                if (n == 0 || $urandom_range(0, 7) == 0)
                    s = $urandom_range(0, 63);
                else
                    s = $urandom_range(0, n - 1);
                queue_request(KIND_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63), s);
                made++;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 64; i++)
            graph_rows[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: full count, cycles, top vertex, reserved kind, isolated start
        queue_request(KIND_ADD, 0, 63, 0);
        queue_request(KIND_ADD, 63, 0, 0);
        queue_request(KIND_ADD, 0, 1, 0);
        queue_request(KIND_ADD, 1, 2, 0);
        queue_request(KIND_ADD, 2, 0, 0);
        queue_request(KIND_ADD, 0, 5, 0);
        queue_request(KIND_SEARCH, 0, 0, 0);
        queue_request(KIND_SEARCH, 0, 0, 63);
        queue_request(KIND_RESERVED, 63, 63, 63);
        queue_request(KIND_SEARCH, 63, 63, 10);
        queue_request(KIND_ADD, 4, 40, 0);
        queue_request(KIND_SEARCH, 0, 0, 4);
        wait_idle();

        // Directed: small count, stale and out-of-range edges, bad starts, clear
        write_vertex_count(5);
        queue_request(KIND_SEARCH, 0, 0, 4);
        queue_request(KIND_ADD, 3, 7, 0);
        queue_request(KIND_ADD, 7, 3, 0);
        queue_request(KIND_ADD, 0, 4, 0);
        queue_request(KIND_SEARCH, 0, 0, 0);
        queue_request(KIND_SEARCH, 0, 0, 5);
        queue_request(KIND_SEARCH, 0, 0, 63);
        queue_request(KIND_CLEAR, 0, 0, 0);
        queue_request(KIND_SEARCH, 0, 0, 0);
        wait_idle();

        // Directed: zero count ignores edges and rejects every start
        write_vertex_count(0);
        queue_request(KIND_ADD, 0, 0, 0);
        queue_request(KIND_SEARCH, 0, 0, 0);
        wait_idle();

        // Random phases across count settings, extremes included
        write_vertex_count(127);
        queue_random_phase(36);
        wait_idle();
        write_vertex_count(1);
        queue_random_phase(36);
        wait_idle();
        write_vertex_count(2);
        queue_random_phase(36);
        wait_idle();
        write_vertex_count(9);
        queue_random_phase(36);
        wait_idle();
        write_vertex_count(64);
        queue_random_phase(36);
        wait_idle();

        // Final phase runs without idling on either side
        write_vertex_count($urandom_range(3, 63));
        quiet = 1'b1;
        queue_random_phase(36);
        wait_idle();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/adfs_pkg.sv
sv/adfs_prio.sv
sv/adfs_matrix.sv
sv/adfs_stack.sv
sv/adjacency_matrix_depth_first_search.sv
test/adjacency_matrix_depth_first_search_tb.sv
